### sv/scq_pkg.sv
`default_nettype none

package scq_pkg;

    localparam int QUEUE_DEPTH = 32;
    localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CODE_W      = 8;
    localparam int CHAR_W      = 7;
    localparam int TABLE_SIZE  = 89;

    localparam logic [CODE_W-1:0] SC_LSHIFT_MAKE  = 8'h2a;
    localparam logic [CODE_W-1:0] SC_RSHIFT_MAKE  = 8'h36;
    localparam logic [CODE_W-1:0] SC_LSHIFT_BREAK = 8'haa;
    localparam logic [CODE_W-1:0] SC_RSHIFT_BREAK = 8'hb6;
    localparam logic [CODE_W-1:0] SC_BACKSPACE    = 8'h0e;

    localparam logic [CHAR_W-1:0] ASCII_BS = 7'h08;

    localparam logic OP_SCAN = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef logic [PTR_W-1:0]  ptr_t;
    typedef logic [CHAR_W-1:0] char_t;

    // Set-1 make code to ASCII; unmapped keys and codes past the table give zero.
    function automatic char_t scq_lookup(input logic [CODE_W-2:0] code, input logic shift);
        char_t plain;
        char_t shifted;
        plain   = '0;
        shifted = '0;
        unique case (code)
            7'd2:    begin plain = 7'h31; shifted = 7'h21; end
            7'd3:    begin plain = 7'h32; shifted = 7'h40; end
            7'd4:    begin plain = 7'h33; shifted = 7'h23; end
            7'd5:    begin plain = 7'h34; shifted = 7'h24; end
            7'd6:    begin plain = 7'h35; shifted = 7'h25; end
            7'd7:    begin plain = 7'h36; shifted = 7'h5e; end
            7'd8:    begin plain = 7'h37; shifted = 7'h26; end
            7'd9:    begin plain = 7'h38; shifted = 7'h2a; end
            7'd10:   begin plain = 7'h39; shifted = 7'h28; end
            7'd11:   begin plain = 7'h30; shifted = 7'h29; end
            7'd12:   begin plain = 7'h2d; shifted = 7'h5f; end
            7'd13:   begin plain = 7'h3d; shifted = 7'h2b; end
            7'd16:   begin plain = 7'h71; shifted = 7'h51; end
            7'd17:   begin plain = 7'h77; shifted = 7'h57; end
            7'd18:   begin plain = 7'h65; shifted = 7'h45; end
            7'd19:   begin plain = 7'h72; shifted = 7'h52; end
            7'd20:   begin plain = 7'h74; shifted = 7'h54; end
            7'd21:   begin plain = 7'h79; shifted = 7'h59; end
            7'd22:   begin plain = 7'h75; shifted = 7'h55; end
            7'd23:   begin plain = 7'h69; shifted = 7'h49; end
            7'd24:   begin plain = 7'h6f; shifted = 7'h4f; end
            7'd25:   begin plain = 7'h70; shifted = 7'h50; end
            7'd26:   begin plain = 7'h5b; shifted = 7'h7b; end
            7'd27:   begin plain = 7'h5d; shifted = 7'h7d; end
            7'd28:   begin plain = 7'h0a; shifted = 7'h0a; end
            7'd30:   begin plain = 7'h61; shifted = 7'h41; end
            7'd31:   begin plain = 7'h73; shifted = 7'h53; end
            7'd32:   begin plain = 7'h64; shifted = 7'h44; end
            7'd33:   begin plain = 7'h66; shifted = 7'h46; end
            7'd34:   begin plain = 7'h67; shifted = 7'h47; end
            7'd35:   begin plain = 7'h68; shifted = 7'h48; end
            7'd36:   begin plain = 7'h6a; shifted = 7'h4a; end
            7'd37:   begin plain = 7'h6b; shifted = 7'h4b; end
            7'd38:   begin plain = 7'h6c; shifted = 7'h4c; end
            7'd39:   begin plain = 7'h3b; shifted = 7'h3a; end
            7'd40:   begin plain = 7'h27; shifted = 7'h22; end
            7'd41:   begin plain = 7'h60; shifted = 7'h7e; end
            7'd43:   begin plain = 7'h5c; shifted = 7'h7c; end
            7'd44:   begin plain = 7'h7a; shifted = 7'h5a; end
            7'd45:   begin plain = 7'h78; shifted = 7'h58; end
            7'd46:   begin plain = 7'h63; shifted = 7'h43; end
            7'd47:   begin plain = 7'h76; shifted = 7'h56; end
            7'd48:   begin plain = 7'h62; shifted = 7'h42; end
            7'd49:   begin plain = 7'h6e; shifted = 7'h4e; end
            7'd50:   begin plain = 7'h6d; shifted = 7'h4d; end
            7'd51:   begin plain = 7'h2c; shifted = 7'h3c; end
            7'd52:   begin plain = 7'h2e; shifted = 7'h3e; end
            7'd53:   begin plain = 7'h2f; shifted = 7'h3f; end
            7'd55:   begin plain = 7'h2a; shifted = 7'h2a; end
            7'd57:   begin plain = 7'h20; shifted = 7'h20; end
            default: begin plain = '0;    shifted = '0;    end
        endcase
        return shift ? shifted : plain;
    endfunction

    // Ring pointer advance that also wraps for depths that are not a power of two.
    function automatic ptr_t scq_ptr_inc(input ptr_t ptr);
        ptr_t nxt;
        if (ptr == PTR_W'(QUEUE_DEPTH - 1))
            nxt = '0;
        else
            nxt = ptr + PTR_W'(1);
        return nxt;
    endfunction

endpackage

`default_nettype wire

### sv/scq_cmd_if.sv
`default_nettype none

interface scq_cmd_if;
    logic                          valid;
    logic                          ready;
    logic                          operation;
    logic                          data_ready;
    logic [scq_pkg::CODE_W-1:0]    scancode;

    modport source (output valid, output operation, output data_ready, output scancode,
                    input ready);
    modport sink   (input valid, input operation, input data_ready, input scancode,
                    output ready);
endinterface

`default_nettype wire

### sv/scq_rsp_if.sv
`default_nettype none

interface scq_rsp_if;
    logic                          valid;
    logic                          ready;
    logic                          got_char;
    logic [scq_pkg::CHAR_W-1:0]    char_code;

    modport source (output valid, output got_char, output char_code, input ready);
    modport sink   (input valid, input got_char, input char_code, output ready);
endinterface

`default_nettype wire

### sv/scancode_to_ascii_queue_unit.sv
// Keyboard scancode (set 1) to ASCII character queue.
//
// cmd channel: one transaction per event. operation = OP_SCAN delivers a
// scancode byte (ignored unless data_ready is set); operation = OP_READ pops
// one character. Scan events produce no response; every read produces one
// response on the rsp channel: got_char = 1 with the character, or got_char
// = 0 and char_code = 0 when the queue is empty.
//
// Latency: a read response is valid the cycle after the read is accepted.
// Throughput: one cmd transaction per cycle when cmd.ready is high; the
// shift flag, the queue RAM and both pointers are updated in the accept
// cycle, so the next event sees them immediately. The queue holds
// QUEUE_DEPTH-1 characters; a character arriving at a full queue is lost.
//
// Reset: queue empty, shift released, no response pending. Queue RAM
// contents are not cleared and are never read before being written.
// Stall: while a response waits and rsp.ready is low, cmd.ready is low.

`default_nettype none

module scancode_to_ascii_queue_unit (
    input  wire          clk,
    input  wire          rst_n,
    scq_cmd_if.sink      cmd,
    scq_rsp_if.source    rsp
);
    import scq_pkg::*;

    char_t queue_mem [QUEUE_DEPTH];

    ptr_t  wr_ptr_reg, wr_ptr_next;
    ptr_t  rd_ptr_reg, rd_ptr_next;
    logic  shift_reg, shift_next;
    logic  rsp_valid_reg, rsp_valid_next;
    logic  got_char_reg;
    char_t char_code_reg;

    logic  cmd_fire;
    logic  scan_evt;
    logic  read_evt;
    logic  q_empty;
    logic  q_full;
    logic  push_req;
    logic  push_en;
    logic  pop_en;
    char_t push_char;

    assign cmd.ready = !rsp_valid_reg || rsp.ready;
    assign cmd_fire  = cmd.valid && cmd.ready;
    assign scan_evt  = cmd_fire && (cmd.operation == OP_SCAN) && cmd.data_ready;
    assign read_evt  = cmd_fire && (cmd.operation == OP_READ);

    assign q_empty = (wr_ptr_reg == rd_ptr_reg);
    assign q_full  = (scq_ptr_inc(wr_ptr_reg) == rd_ptr_reg);

    always_comb
    begin
        shift_next = shift_reg;
        push_req   = 1'b0;
        push_char  = '0;
        if (scan_evt)
        begin
            priority if (cmd.scancode == SC_LSHIFT_MAKE || cmd.scancode == SC_RSHIFT_MAKE)
            begin
                shift_next = 1'b1;
            end
            else if (cmd.scancode == SC_LSHIFT_BREAK || cmd.scancode == SC_RSHIFT_BREAK)
            begin
                shift_next = 1'b0;
            end
            else if (cmd.scancode == SC_BACKSPACE)
            begin
                push_req  = 1'b1;
                push_char = ASCII_BS;
            end
            else if (!cmd.scancode[CODE_W-1] && (cmd.scancode < CODE_W'(TABLE_SIZE)))
            begin
                push_char = scq_lookup(cmd.scancode[CODE_W-2:0], shift_reg);
                push_req  = (push_char != '0);
            end
            else
            begin
                // drop other releases and codes past the table
                push_req = 1'b0;
            end
        end
    end

    assign push_en = push_req && !q_full;
    assign pop_en  = read_evt && !q_empty;

    assign wr_ptr_next    = push_en ? scq_ptr_inc(wr_ptr_reg) : wr_ptr_reg;
    assign rd_ptr_next    = pop_en  ? scq_ptr_inc(rd_ptr_reg) : rd_ptr_reg;
    assign rsp_valid_next = read_evt ? 1'b1 : (rsp_valid_reg && !rsp.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            shift_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            wr_ptr_reg    <= wr_ptr_next;
            rd_ptr_reg    <= rd_ptr_next;
            shift_reg     <= shift_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_en)
            queue_mem[wr_ptr_reg] <= push_char;
    end

    // Registered RAM read lands straight in the response register.
    always_ff @(posedge clk)
    begin
        if (read_evt)
        begin
            got_char_reg  <= !q_empty;
            char_code_reg <= q_empty ? '0 : queue_mem[rd_ptr_reg];
        end
    end

    assign rsp.valid     = rsp_valid_reg;
    assign rsp.got_char  = got_char_reg;
    assign rsp.char_code = char_code_reg;

    a_empty_read_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (read_evt && q_empty) |=> (rsp_valid_reg && !got_char_reg && char_code_reg == '0))
        else $error("empty read did not return a null response");

    a_scan_keeps_rd_ptr: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_fire && cmd.operation == OP_SCAN) |=> $stable(rd_ptr_reg))
        else $error("scan event moved the read pointer");

    a_read_keeps_wr_ptr: assert property (@(posedge clk) disable iff (!rst_n)
        read_evt |=> ($stable(wr_ptr_reg) && $stable(shift_reg)))
        else $error("read changed the write pointer or shift flag");

    a_ptr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_ptr_reg <= PTR_W'(QUEUE_DEPTH - 1)) && (rd_ptr_reg <= PTR_W'(QUEUE_DEPTH - 1)))
        else $error("queue pointer out of range");

    a_full_no_push: assert property (@(posedge clk) disable iff (!rst_n)
        (push_req && q_full) |=> $stable(wr_ptr_reg))
        else $error("push into a full queue advanced the write pointer");

endmodule

`default_nettype wire
